@@ hdl/tatf_pkg.sv @@
// Shared types, request and quantity codes and the tilt lookup for the
// tilt averager and temperature formatter. No dependencies.
package tatf_pkg;

  localparam int unsigned RING_DEPTH_DEF = 8;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned AXIS_W    = 6;
  localparam int unsigned AXES      = 3;
  localparam int unsigned SAMPLE_W  = AXES * AXIS_W;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned TVAL_W    = 13;
  localparam int unsigned QTY_W     = 2;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MAGN_W    = 13;
  localparam int unsigned TILT_W    = 10;
  localparam int unsigned AXIS_Q_W  = 10;
  localparam int unsigned TILT_MAX  = 900;

  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

  localparam logic [QTY_W-1:0] QTY_X    = 2'd0;
  localparam logic [QTY_W-1:0] QTY_Y    = 2'd1;
  localparam logic [QTY_W-1:0] QTY_Z    = 2'd2;
  localparam logic [QTY_W-1:0] QTY_TEMP = 2'd3;

  localparam logic [TILT_W-1:0] TILT_TABLE [32] = '{
    10'd0,   10'd27,  10'd54,  10'd81,  10'd108, 10'd135, 10'd163, 10'd192,
    10'd220, 10'd250, 10'd280, 10'd310, 10'd342, 10'd375, 10'd410, 10'd447,
    10'd486, 10'd528, 10'd575, 10'd630, 10'd696, 10'd799, 10'd900, 10'd900,
    10'd900, 10'd900, 10'd900, 10'd900, 10'd900, 10'd900, 10'd900, 10'd900
  };

  typedef struct packed {
    logic              valid;
    logic [QTY_W-1:0]  quantity;
    logic              negative;
    logic [MAGN_W-1:0] magnitude;
  } fmt_req_t;

  // signed tenths of a degree; the most negative code saturates to the last entry
  function automatic logic signed [TILT_W:0] tilt_of(input logic [AXIS_W-1:0] code);
    logic [AXIS_W-1:0] neg_c;
    logic [4:0]        idx;
    logic [TILT_W-1:0] m;
    neg_c = 6'd0 - code;
    if (code[AXIS_W-1]) begin
      idx = neg_c[5] ? 5'd31 : neg_c[4:0];
    end else begin
      idx = code[4:0];
    end
    m = TILT_TABLE[idx];
    return code[AXIS_W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

@@ hdl/tatf_if.sv @@
// Request and result channel interfaces for the tilt averager.
// Depends on tatf_pkg.
interface tatf_req_if import tatf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [AXIS_W-1:0] axis_x;
  logic [AXIS_W-1:0] axis_y;
  logic [AXIS_W-1:0] axis_z;
  logic [TEMP_W-1:0] temp_word;

  modport source (output valid, req_type, axis_x, axis_y, axis_z, temp_word, input ready);
  modport sink   (input valid, req_type, axis_x, axis_y, axis_z, temp_word, output ready);
endinterface

interface tatf_res_if import tatf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [QTY_W-1:0]   quantity;
  logic               negative;
  logic [DIGIT_W-1:0] digit_high;
  logic [DIGIT_W-1:0] digit_mid;
  logic [DIGIT_W-1:0] digit_low;
  logic [MAGN_W-1:0]  magnitude;
  logic               last;

  modport source (output valid, quantity, negative, digit_high, digit_mid, digit_low,
                  magnitude, last, input ready);
  modport sink   (input valid, quantity, negative, digit_high, digit_mid, digit_low,
                  magnitude, last, output ready);
endinterface

@@ hdl/tilt_average_and_temp_formatter_unit.sv @@
// Top level of the tilt averager and temperature formatter.
// Depends on tatf_pkg, tatf_if, tatf_ring, tatf_div and tatf_fmt.
//
// Store and load beats are taken only in the idle state. A report beat walks
// the sample ring through its single read port, one entry per cycle,
// accumulating each entry once its registered read returns, then divides
// the three axis sums by RING_DEPTH with a registered reciprocal
// multiplication, then hands four results to the two-stage formatter, one
// per cycle while the sink keeps up; the next beat is taken only after the
// fourth handoff. The last result then still passes the formatter's stage A
// and result registers. A stalled sink holds the handoff and with it the
// request channel. Ring entries never written since reset read as zero;
// there is no clearing pass.
module tilt_average_and_temp_formatter_unit import tatf_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tatf_req_if.sink   req_i,
  tatf_res_if.source res_o
);

  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned MAG_W  = $clog2(TILT_MAX * RING_DEPTH + 1);
  localparam int unsigned SUM_W  = MAG_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [CNT_W-1:0]              cnt_q;
  logic                          pend_q;
  logic [QTY_W-1:0]              qty_q;
  logic [TVAL_W-1:0]             temp_q;
  logic signed [SUM_W-1:0]       sum_q [AXES];

  logic                          req_acc;
  logic                          wr_en;
  logic                          rd_en;
  logic                          div_start;
  logic                          div_done;
  logic [SAMPLE_W-1:0]           ring_data;
  logic [AXES-1:0][MAG_W-1:0]    div_mag;
  logic [AXES-1:0][AXIS_Q_W-1:0] quo;
  fmt_req_t                      fmt_req;
  logic                          fmt_ready;
  logic                          lane_sign;
  logic [AXIS_Q_W-1:0]           lane_quo;
  logic [TVAL_W-1:0]             temp_mag;

  assign req_i.ready = state_q == S_IDLE;
  assign req_acc     = req_i.valid && req_i.ready;
  assign wr_en       = req_acc && (req_i.req_type == REQ_STORE);
  assign rd_en       = (state_q == S_ACC) && (cnt_q != CNT_W'(RING_DEPTH));
  assign div_start   = (state_q == S_ACC) && (cnt_q == CNT_W'(RING_DEPTH)) && !pend_q;

  tatf_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i ({req_i.axis_z, req_i.axis_y, req_i.axis_x}),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[SLOT_W-1:0]),
    .rd_data_o (ring_data)
  );

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      div_mag[a] = MAG_W'(sum_q[a][SUM_W-1] ? -sum_q[a] : sum_q[a]);
    end
  end

  tatf_div #(.RING_DEPTH(RING_DEPTH), .MAG_W(MAG_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  always_comb begin
    temp_mag = temp_q[TVAL_W-1] ? (~temp_q + 1'b1) : temp_q;
    case (qty_q)
      QTY_X: begin
        lane_sign = sum_q[0][SUM_W-1];
        lane_quo  = quo[0];
      end
      QTY_Y: begin
        lane_sign = sum_q[1][SUM_W-1];
        lane_quo  = quo[1];
      end
      QTY_Z: begin
        lane_sign = sum_q[2][SUM_W-1];
        lane_quo  = quo[2];
      end
      default: begin
        lane_sign = 1'b0;
        lane_quo  = '0;
      end
    endcase
    fmt_req          = '0;
    fmt_req.valid    = state_q == S_EMIT;
    fmt_req.quantity = qty_q;
    if (qty_q == QTY_TEMP) begin
      fmt_req.negative  = temp_q[TVAL_W-1];
      fmt_req.magnitude = MAGN_W'(temp_mag);
    end else begin
      fmt_req.negative  = lane_sign && (lane_quo != '0);
      fmt_req.magnitude = MAGN_W'(lane_quo);
    end
  end

  tatf_fmt u_fmt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (fmt_req),
    .ready_o (fmt_ready),
    .res_o   (res_o)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc && (req_i.req_type == REQ_REPORT)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (div_start) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (fmt_ready && (qty_q == QTY_TEMP)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AXES; a++) begin
      if (req_acc && (req_i.req_type == REQ_REPORT)) begin
        sum_q[a] <= '0;
      end else if ((state_q == S_ACC) && pend_q) begin
        sum_q[a] <= sum_q[a] + SUM_W'(tilt_of(ring_data[a*AXIS_W +: AXIS_W]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      qty_q   <= QTY_X;
      temp_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (req_acc && (req_i.req_type == REQ_LOAD)) begin
        temp_q <= req_i.temp_word[TEMP_W-1:3];
      end
      if (req_acc && (req_i.req_type == REQ_REPORT)) begin
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (div_done) begin
        qty_q <= QTY_X;
      end else if ((state_q == S_EMIT) && fmt_ready && (qty_q != QTY_TEMP)) begin
        qty_q <= qty_q + 1'b1;
      end
    end
  end

endmodule

@@ hdl/tatf_ring.sv @@
// Sample ring: synchronous memory with one write and one registered read
// port, per-entry valid bits and the write slot pointer. Depends on tatf_pkg.
module tatf_ring import tatf_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [SAMPLE_W-1:0]           wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_addr_i,
  output logic [SAMPLE_W-1:0]           rd_data_o
);

  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);

  logic [SAMPLE_W-1:0]   mem_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SAMPLE_W-1:0]   data_q;
  logic                  hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[slot_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      slot_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = hit_q ? data_q : '0;

endmodule

@@ hdl/tatf_div.sv @@
// Divider of the three axis magnitudes by the ring depth, one reciprocal
// multiplication per lane, quotients registered on start and flagged by done_o. Depends on tatf_pkg.
module tatf_div import tatf_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned MAG_W      = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [AXES-1:0][MAG_W-1:0]   mag_i,
  output logic [AXES-1:0][AXIS_Q_W-1:0] quo_o,
  output logic                         done_o
);

  localparam int unsigned SH_W   = $clog2(RING_DEPTH);
  localparam int unsigned SHIFT  = MAG_W + SH_W;
  localparam int unsigned RCP_W  = MAG_W + 1;
  localparam int unsigned PROD_W = MAG_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  logic [AXES-1:0][PROD_W-1:0]   prod;
  logic [AXES-1:0][AXIS_Q_W-1:0] quo_q;
  logic                          done_q;

  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      prod[l] = PROD_W'(mag_i[l]) * PROD_W'(RCP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int l = 0; l < AXES; l++) begin
        quo_q[l] <= AXIS_Q_W'(prod[l] >> SHIFT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

@@ hdl/tatf_fmt.sv @@
// Decimal formatter: two register stages that split a magnitude into
// three digits, the second stage being the result channel register. Depends on tatf_pkg.
module tatf_fmt import tatf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fmt_req_t   req_i,
  output logic       ready_o,
  tatf_res_if.source res_o
);

  logic               a_vld_q;
  logic [QTY_W-1:0]   a_qty_q;
  logic               a_neg_q;
  logic [MAGN_W-1:0]  a_mag_q;
  logic [DIGIT_W-1:0] a_h_q;
  logic [6:0]         a_r_q;

  logic               res_vld_q;
  logic [QTY_W-1:0]   quantity_q;
  logic               negative_q;
  logic [DIGIT_W-1:0] digit_high_q;
  logic [DIGIT_W-1:0] digit_mid_q;
  logic [DIGIT_W-1:0] digit_low_q;
  logic [MAGN_W-1:0]  magnitude_q;
  logic               last_q;

  logic [15:0]        axis_prod;
  logic [DIGIT_W-1:0] axis_h;
  logic [9:0]         axis_r;
  logic [8:0]         whole;
  logic [8:0]         temp_r;
  logic [7:0]         frac_prod;
  logic               is_temp;
  logic [DIGIT_W-1:0] h_d;
  logic [6:0]         r_d;
  logic [14:0]        tens_prod;
  logic [DIGIT_W-1:0] tens;
  logic [6:0]         units_w;
  logic               b_free;

  always_comb begin
    axis_prod = 16'(req_i.magnitude[9:0]) * 16'd41;
    axis_h    = axis_prod[15:12];
    axis_r    = req_i.magnitude[9:0] - 10'(axis_h) * 10'd100;
    whole     = req_i.magnitude[12:4];
    if (whole >= 9'd200) begin
      temp_r = whole - 9'd200;
    end else if (whole >= 9'd100) begin
      temp_r = whole - 9'd100;
    end else begin
      temp_r = whole;
    end
    frac_prod = 8'(req_i.magnitude[3:0]) * 8'd10;
    is_temp   = req_i.quantity == QTY_TEMP;
    h_d       = is_temp ? frac_prod[7:4] : axis_h;
    r_d       = is_temp ? temp_r[6:0] : axis_r[6:0];
  end

  always_comb begin
    tens_prod = 15'(a_r_q) * 15'd205;
    tens      = tens_prod[14:11];
    units_w   = a_r_q - 7'(tens) * 7'd10;
  end

  assign b_free  = !res_vld_q || res_o.ready;
  assign ready_o = !a_vld_q || b_free;

  always_ff @(posedge clk_i) begin
    if (ready_o && req_i.valid) begin
      a_qty_q <= req_i.quantity;
      a_neg_q <= req_i.negative;
      a_mag_q <= req_i.magnitude;
      a_h_q   <= h_d;
      a_r_q   <= r_d;
    end
    if (b_free && a_vld_q) begin
      quantity_q  <= a_qty_q;
      negative_q  <= a_neg_q;
      magnitude_q <= a_mag_q;
      last_q      <= a_qty_q == QTY_TEMP;
      if (a_qty_q == QTY_TEMP) begin
        digit_high_q <= tens;
        digit_mid_q  <= units_w[3:0];
        digit_low_q  <= a_h_q;
      end else begin
        digit_high_q <= a_h_q;
        digit_mid_q  <= tens;
        digit_low_q  <= units_w[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (ready_o) begin
        a_vld_q <= req_i.valid;
      end
      if (b_free) begin
        res_vld_q <= a_vld_q;
      end
    end
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.quantity   = quantity_q;
  assign res_o.negative   = negative_q;
  assign res_o.digit_high = digit_high_q;
  assign res_o.digit_mid  = digit_mid_q;
  assign res_o.digit_low  = digit_low_q;
  assign res_o.magnitude  = magnitude_q;
  assign res_o.last       = last_q;

endmodule

@@ hdl/tatf_chk.sv @@
// Port-level checker for the tilt averager, bound to the top level.
// Depends on tatf_pkg and tilt_average_and_temp_formatter_unit.
module tatf_chk import tatf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic [REQ_W-1:0]   req_type_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [QTY_W-1:0]   quantity_i,
  input logic               negative_i,
  input logic [DIGIT_W-1:0] digit_high_i,
  input logic [DIGIT_W-1:0] digit_mid_i,
  input logic [DIGIT_W-1:0] digit_low_i,
  input logic [MAGN_W-1:0]  magnitude_i,
  input logic               last_i
);

  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && (req_type_i == REQ_REPORT)) |=> !req_ready_i)
    else $error("ready held high after a report beat");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(quantity_i) && $stable(magnitude_i) && $stable(last_i)))
    else $error("stalled result beat changed");

  a_axis_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (quantity_i != QTY_TEMP)) |->
      (magnitude_i == (13'(digit_high_i) * 13'd100 + 13'(digit_mid_i) * 13'd10
                       + 13'(digit_low_i))))
    else $error("axis digits disagree with magnitude");

  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && negative_i) |-> (magnitude_i != '0))
    else $error("negative zero result");

  a_last_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (last_i == (quantity_i == QTY_TEMP)))
    else $error("last flag not on the temperature beat");

endmodule

bind tilt_average_and_temp_formatter_unit tatf_chk u_tatf_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .quantity_i   (res_o.quantity),
  .negative_i   (res_o.negative),
  .digit_high_i (res_o.digit_high),
  .digit_mid_i  (res_o.digit_mid),
  .digit_low_i  (res_o.digit_low),
  .magnitude_i  (res_o.magnitude),
  .last_i       (res_o.last)
);
